[hdl/rsook_pkg.sv]
// Shared types, constants and register indexes for the remote switch OOK encoder.
package rsook_pkg;

    // Default code word length
    localparam int WORD_BITS_DEF = 12;

    // Configuration register widths and reset values
    localparam int UNIT_W = 16;
    localparam int REP_W  = 8;
    localparam int CFG_W  = 16;
    localparam logic [UNIT_W-1:0] UNIT_TICKS_RST   = 16'd230;
    localparam logic [REP_W-1:0]  REPEAT_COUNT_RST = 8'd16;

    // Configuration register indexes
    localparam logic CFG_UNIT_TICKS   = 1'b0;
    localparam logic CFG_REPEAT_COUNT = 1'b1;

    // Command field widths and code word layout
    localparam int CHAN_W  = 4;
    localparam int CH_LSB  = 1;
    localparam int ON_BIT  = 8;

    // Pulse lengths in units
    localparam int UNITS_W = 5;
    localparam logic [UNITS_W-1:0] LONG_UNITS     = 5'd3;
    localparam logic [UNITS_W-1:0] SHORT_UNITS    = 5'd1;
    localparam logic [UNITS_W-1:0] SYNC_LOW_UNITS = 5'd31;

    // Input mode codes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // One result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic refused;
    } t_result;

endpackage

[hdl/remote_switch_ook_encoder_unit.sv]
// The result of an item is registered and appears in the cycle after its transfer is accepted.
// Throughput: one item per cycle; the next item is taken while a result still waits,
// as long as the output register is empty or is being drained in the same cycle.
// Reset (synchronous, active low) makes the encoder idle with the line low and loads
// unit_ticks = 230 and repeat_count = 16.
module remote_switch_ook_encoder_unit #(
    parameter int WORD_BITS = rsook_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [rsook_pkg::CHAN_W-1:0]  i_channel,
    input  logic                          i_switch_on,
    // Output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_line_level,
    output logic                          o_busy_res,
    output logic                          o_refused,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [rsook_pkg::CFG_W-1:0]   i_cfg_data
);
    import rsook_pkg::*;

    logic [UNIT_W-1:0] r_unit_ticks;
    logic [REP_W-1:0]  r_repeat_count;
    logic              r_out_valid;
    t_result           r_res;
    t_result           seq_res;
    logic              in_xfer;
    logic              out_xfer;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks   <= UNIT_TICKS_RST;
            r_repeat_count <= REPEAT_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNIT_TICKS:   r_unit_ticks   <= i_cfg_data[UNIT_W-1:0];
                CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[REP_W-1:0];
                default: ;
            endcase
        end
    end

    rsook_seq #(
        .WORD_BITS(WORD_BITS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_xfer),
        .i_mode         (i_mode),
        .i_channel      (i_channel),
        .i_switch_on    (i_switch_on),
        .i_unit_ticks   (r_unit_ticks),
        .i_repeat_count (r_repeat_count),
        .o_res          (seq_res)
    );

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= seq_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_res.line_level;
    assign o_busy_res   = r_res.busy_res;
    assign o_refused    = r_res.refused;

    // Every accepted item leaves a result behind
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("accepted item produced no result");

    // A refusal only happens while a transmission runs
    a_refused_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.refused |-> r_res.busy_res)
        else $error("refused without busy");

    // The line is never driven high while idle
    a_level_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.line_level |-> r_res.busy_res)
        else $error("line high while idle");

    // A waiting result is not overwritten
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !in_xfer)
        else $error("result overwritten while stalled");

endmodule

[hdl/rsook_seq.sv]
// Waveform sequencer: frame, bit, symbol, unit and tick counters of the encoder.
module rsook_seq #(
    parameter int WORD_BITS = rsook_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_mode,
    input  logic [rsook_pkg::CHAN_W-1:0]  i_channel,
    input  logic                          i_switch_on,
    input  logic [rsook_pkg::UNIT_W-1:0]  i_unit_ticks,
    input  logic [rsook_pkg::REP_W-1:0]   i_repeat_count,
    output rsook_pkg::t_result            o_res
);
    import rsook_pkg::*;

    localparam int IDX_W = $clog2(WORD_BITS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] r_code, n_code;
    logic [REP_W-1:0]     r_frame_left, n_frame_left;
    logic [IDX_W-1:0]     r_bit_idx, n_bit_idx;
    logic                 r_second, n_second;
    logic                 r_high, n_high;
    logic                 r_sync, n_sync;
    logic [UNITS_W-1:0]   r_units, n_units;
    logic [UNIT_W-1:0]    r_ticks, n_ticks;
    logic                 r_active, n_active;

    logic [UNIT_W-1:0]    unit_len;
    logic [UNIT_W-1:0]    ticks_dec;
    logic [UNITS_W-1:0]   units_dec;
    logic [REP_W-1:0]     frame_dec;
    logic [2:0]           ch_code;
    logic                 cur_bit;
    logic                 next_bit;

    assign unit_len  = (i_unit_ticks == '0) ? UNIT_W'(1) : i_unit_ticks;
    assign ticks_dec = r_ticks - UNIT_W'(1);
    assign units_dec = r_units - UNITS_W'(1);
    assign frame_dec = r_frame_left - REP_W'(1);
    assign ch_code   = 3'(i_channel - CHAN_W'(1));
    assign cur_bit   = r_code[r_bit_idx];
    assign next_bit  = r_code[r_bit_idx + IDX_W'(1)];

    // Result of the current item, taken from state before it is updated
    always_comb begin
        o_res.busy_res   = r_active;
        o_res.line_level = r_active && r_high;
        o_res.refused    = 1'b0;
        if (i_mode == MODE_CMD) begin
            if (r_active) begin
                o_res.refused = 1'b1;
            end else begin
                o_res.busy_res   = 1'b1;
                o_res.line_level = 1'b1;
            end
        end
    end

    // Next state for a command or a tick
    always_comb begin
        n_code       = r_code;
        n_frame_left = r_frame_left;
        n_bit_idx    = r_bit_idx;
        n_second     = r_second;
        n_high       = r_high;
        n_sync       = r_sync;
        n_units      = r_units;
        n_ticks      = r_ticks;
        n_active     = r_active;
        if (i_mode == MODE_CMD) begin
            // Start a transmission unless one is running
            if (!r_active) begin
                n_code = '0;
                n_code[CH_LSB +: 3] = ~ch_code;
                n_code[ON_BIT]      = i_switch_on;
                n_frame_left = (i_repeat_count == '0) ? REP_W'(1) : i_repeat_count;
                n_ticks      = unit_len;
                n_active     = 1'b1;
                n_bit_idx    = '0;
                n_second     = 1'b0;
                n_high       = 1'b1;
                n_sync       = 1'b0;
                n_units      = n_code[0] ? LONG_UNITS : SHORT_UNITS;
            end
        end else if (r_active) begin
            if (ticks_dec != '0) begin
                n_ticks = ticks_dec;
            end else begin
                // Unit boundary
                n_ticks = unit_len;
                n_units = units_dec;
                if (units_dec == '0) begin
                    if (r_high) begin
                        n_high  = 1'b0;
                        n_units = r_sync ? SYNC_LOW_UNITS
                                         : (cur_bit ? SHORT_UNITS : LONG_UNITS);
                    end else if (r_sync) begin
                        // End of frame: repeat or finish
                        n_frame_left = frame_dec;
                        if (frame_dec == '0) begin
                            n_active = 1'b0;
                            n_sync   = 1'b0;
                        end else begin
                            n_bit_idx = '0;
                            n_second  = 1'b0;
                            n_high    = 1'b1;
                            n_sync    = 1'b0;
                            n_units   = r_code[0] ? LONG_UNITS : SHORT_UNITS;
                        end
                    end else if (!r_second) begin
                        n_second = 1'b1;
                        n_high   = 1'b1;
                        n_units  = cur_bit ? LONG_UNITS : SHORT_UNITS;
                    end else begin
                        n_second = 1'b0;
                        n_high   = 1'b1;
                        if (r_bit_idx >= LAST_IDX) begin
                            n_sync  = 1'b1;
                            n_units = SHORT_UNITS;
                        end else begin
                            n_bit_idx = r_bit_idx + IDX_W'(1);
                            n_units   = next_bit ? LONG_UNITS : SHORT_UNITS;
                        end
                    end
                end
            end
        end
    end

    // State registers, updated on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code       <= '0;
            r_frame_left <= '0;
            r_bit_idx    <= '0;
            r_second     <= 1'b0;
            r_high       <= 1'b0;
            r_sync       <= 1'b0;
            r_units      <= '0;
            r_ticks      <= '0;
            r_active     <= 1'b0;
        end else if (i_step) begin
            r_code       <= n_code;
            r_frame_left <= n_frame_left;
            r_bit_idx    <= n_bit_idx;
            r_second     <= n_second;
            r_high       <= n_high;
            r_sync       <= n_sync;
            r_units      <= n_units;
            r_ticks      <= n_ticks;
            r_active     <= n_active;
        end
    end

endmodule
